### hw/rtl/smap_pkg.sv
// Shared types, constants and helpers for the STUN mapped address parser.
// No dependencies; every other file of the block depends on this package.
package smap_pkg;

   localparam logic [15:0] KIND_XOR_MAPPED = 16'h0020;
   localparam logic [15:0] PORT_MASK       = 16'h2112;
   localparam logic [31:0] IP_MASK         = 32'h2112A442;
   localparam logic [7:0]  TYPE_BYTE       = 8'h01;
   localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
   localparam int          MIN_RESPONSE    = 32;
   localparam int          ATTR_START      = 20;
   localparam int          QUEUE_DEPTH     = 4;
   localparam int          QPTR_W          = $clog2(QUEUE_DEPTH);

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_SHORT   = 2'd1;
   localparam status_type STATUS_NO_ADDR = 2'd2;

   // Role of a byte inside the response, decided by the front end.
   typedef enum logic [2:0] {
      CLS_HEADER,
      CLS_LEN_HI,
      CLS_LEN_LO,
      CLS_SKIP,
      CLS_WALK
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data;
      logic           last;
      logic           short_resp;
      byte_class_type cls;
   } entry_type;

   // Attribute cost: header plus value length rounded up to four bytes.
   function automatic logic [16:0] attr_cost(input logic [15:0] len);
      logic [16:0] up;
      up = {1'b0, len} + 17'd3;
      return {up[16:2], 2'b00} + 17'd4;
   endfunction

endpackage

### hw/rtl/smap_if.sv
// Valid/ready channel interfaces for request bytes and parse results.
// Depends on smap_pkg for the status type.
interface smap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       is_last;

   modport source (output valid, output rx_byte, output is_last, input ready);
   modport sink   (input valid, input rx_byte, input is_last, output ready);
endinterface

interface smap_rsp_if;
   logic                valid;
   logic                ready;
   smap_pkg::status_type status;
   logic [31:0]         mapped_ip;
   logic [15:0]         mapped_port;
   logic                discovered;

   modport source (output valid, output status, output mapped_ip, output mapped_port,
                   output discovered, input ready);
   modport sink   (input valid, input status, input mapped_ip, input mapped_port,
                   input discovered, output ready);
endinterface

### hw/rtl/smap_front.sv
// Front end: accepts request bytes, counts position and classifies each byte.
// Depends on smap_pkg and smap_req_if.
module smap_front #(
   parameter int MAX_MESSAGE_BYTES = 2048
) (
   input  logic                clock,
   input  logic                reset,
   smap_req_if.sink            req,
   output logic                push_valid,
   input  logic                push_ready,
   output smap_pkg::entry_type push_entry
);
   import smap_pkg::*;

   localparam int PosW = $clog2(MAX_MESSAGE_BYTES + 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic            counted;
   logic            accept;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;
   assign counted    = (pos_ff != PosW'(MAX_MESSAGE_BYTES));

   always_comb begin
      push_entry.data       = req.rx_byte;
      push_entry.last       = req.is_last;
      push_entry.short_resp = counted && (pos_ff < PosW'(MIN_RESPONSE - 1));
      if (!counted) begin
         push_entry.cls = CLS_SKIP;
      end else if (pos_ff < PosW'(2)) begin
         push_entry.cls = CLS_HEADER;
      end else if (pos_ff == PosW'(2)) begin
         push_entry.cls = CLS_LEN_HI;
      end else if (pos_ff == PosW'(3)) begin
         push_entry.cls = CLS_LEN_LO;
      end else if (pos_ff < PosW'(ATTR_START)) begin
         push_entry.cls = CLS_SKIP;
      end else begin
         push_entry.cls = CLS_WALK;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req.is_last) begin
            pos_in = '0;
         end else if (counted) begin
            pos_in = pos_ff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### hw/rtl/smap_queue.sv
// Short FIFO of classified bytes between front end and attribute walker.
// Depends on smap_pkg for the entry type and depth.
module smap_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  smap_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop,
   output smap_pkg::entry_type pop_entry
);
   import smap_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

### hw/rtl/smap_back.sv
// Back end: header check, TLV attribute walk, endpoint latch and result register.
// Depends on smap_pkg and smap_rsp_if.
module smap_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop,
   input  smap_pkg::entry_type pop_entry,
   smap_rsp_if.source          rsp
);
   import smap_pkg::*;

   logic        header_bad_ff, header_bad_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [15:0] budget_ff, budget_in;
   logic [16:0] rel_ff, rel_in;
   logic [15:0] kind_ff, kind_in;
   logic [15:0] alen_ff, alen_in;
   logic        stopped_ff, stopped_in;
   logic        found_ff, found_in;
   logic [47:0] capture_ff, capture_in;
   logic [31:0] saved_ip_ff, saved_ip_in;
   logic [15:0] saved_port_ff, saved_port_in;
   logic        known_ff, known_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [31:0] ip_ff;
   logic [15:0] port_ff;
   logic        disc_ff;

   logic [16:0] cur_cost, new_cost, r;
   logic [15:0] new_len;
   logic [7:0]  b;

   assign b        = pop_entry.data;
   assign pop      = pop_valid && (!pop_entry.last || !rsp_valid_ff || rsp.ready);
   assign cur_cost = attr_cost(alen_ff);
   assign new_len  = {alen_ff[15:8], b};
   assign new_cost = attr_cost(new_len);
   assign r        = (rel_ff >= 17'd4 && rel_ff == cur_cost) ? '0 : rel_ff;

   always_comb begin
      header_bad_in = header_bad_ff;
      len_hi_in     = len_hi_ff;
      budget_in     = budget_ff;
      rel_in        = rel_ff;
      kind_in       = kind_ff;
      alen_in       = alen_ff;
      stopped_in    = stopped_ff;
      found_in      = found_ff;
      capture_in    = capture_ff;
      saved_ip_in   = saved_ip_ff;
      saved_port_in = saved_port_ff;
      known_in      = known_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;

      if (pop) begin
         unique case (pop_entry.cls)
            CLS_HEADER: begin
               if (b != TYPE_BYTE) begin
                  header_bad_in = 1'b1;
               end
            end
            CLS_LEN_HI: len_hi_in = b;
            CLS_LEN_LO: begin
               budget_in = {len_hi_ff, b};
               rel_in    = '0;
            end
            CLS_WALK: begin
               if (!stopped_ff && !found_ff) begin
                  rel_in = r + 17'd1;
                  if (r == 17'd0) begin
                     if (budget_ff < 16'd4) begin
                        stopped_in = 1'b1;
                     end else begin
                        kind_in = {b, 8'h00};
                     end
                  end else if (r == 17'd1) begin
                     kind_in = {kind_ff[15:8], b};
                  end else if (r == 17'd2) begin
                     alen_in = {b, 8'h00};
                  end else if (r == 17'd3) begin
                     alen_in = new_len;
                     if (new_cost > {1'b0, budget_ff}) begin
                        stopped_in = 1'b1;
                     end else begin
                        budget_in = budget_ff - new_cost[15:0];
                     end
                  end else if (kind_ff == KIND_XOR_MAPPED && alen_ff >= 16'd8
                               && r <= 17'd11) begin
                     // family byte decides whether this attribute stays a candidate
                     if (r == 17'd5) begin
                        if (b != FAMILY_IPV4) begin
                           kind_in = '0;
                        end
                     end else if (r >= 17'd6) begin
                        capture_in = {capture_ff[39:0], b};
                        if (r == 17'd11) begin
                           found_in = 1'b1;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase

         if (pop_entry.last) begin
            if (pop_entry.short_resp) begin
               status_in = STATUS_SHORT;
            end else if (header_bad_in || !found_in) begin
               status_in = STATUS_NO_ADDR;
            end else begin
               status_in     = STATUS_OK;
               saved_port_in = capture_in[47:32] ^ PORT_MASK;
               saved_ip_in   = capture_in[31:0] ^ IP_MASK;
               known_in      = 1'b1;
            end
            rsp_valid_in  = 1'b1;
            // drop per-response state, keep the latched endpoint
            header_bad_in = 1'b0;
            len_hi_in     = '0;
            budget_in     = '0;
            rel_in        = '0;
            kind_in       = '0;
            alen_in       = '0;
            stopped_in    = 1'b0;
            found_in      = 1'b0;
            capture_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_bad_ff <= 1'b0;
         len_hi_ff     <= '0;
         budget_ff     <= '0;
         rel_ff        <= '0;
         kind_ff       <= '0;
         alen_ff       <= '0;
         stopped_ff    <= 1'b0;
         found_ff      <= 1'b0;
         capture_ff    <= '0;
         saved_ip_ff   <= '0;
         saved_port_ff <= '0;
         known_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         header_bad_ff <= header_bad_in;
         len_hi_ff     <= len_hi_in;
         budget_ff     <= budget_in;
         rel_ff        <= rel_in;
         kind_ff       <= kind_in;
         alen_ff       <= alen_in;
         stopped_ff    <= stopped_in;
         found_ff      <= found_in;
         capture_ff    <= capture_in;
         saved_ip_ff   <= saved_ip_in;
         saved_port_ff <= saved_port_in;
         known_ff      <= known_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result payload, loaded only when a last byte is retired
   always_ff @(posedge clock) begin
      if (pop && pop_entry.last) begin
         status_ff <= status_in;
         ip_ff     <= saved_ip_in;
         port_ff   <= saved_port_in;
         disc_ff   <= known_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.mapped_ip   = ip_ff;
   assign rsp.mapped_port = port_ff;
   assign rsp.discovered  = disc_ff;

endmodule

### hw/rtl/stun_mapped_address_parser_top.sv
// STUN Binding response parser: one byte per transfer, one result per response.
// Throughput: one byte per cycle unless stalled; classifier and walker each retire a byte a cycle.
// The last byte passes through the queue and then the result register before the result is valid.
// A held result stalls the walker only at the next last byte; the four-entry queue absorbs the rest.
// Reset (synchronous, active high) clears the queue, all parse state and the latched endpoint.
// Depends on smap_pkg, smap_if, smap_front, smap_queue and smap_back.
module stun_mapped_address_parser_top #(
   parameter int MAX_MESSAGE_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   smap_req_if.sink    req_chan,
   smap_rsp_if.source  rsp_chan
);
   import smap_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop;
   entry_type pop_entry;

   smap_front #(
      .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   smap_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   smap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_entry (pop_entry),
      .rsp       (rsp_chan)
   );

endmodule

### hw/rtl/smap_checker.sv
// Port-level checks for the STUN mapped address parser, bound to the top level.
// Depends on smap_pkg for status codes.
module smap_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input smap_pkg::status_type rsp_status,
   input logic [31:0]          rsp_ip,
   input logic [15:0]          rsp_port,
   input logic                 rsp_disc
);
   import smap_pkg::*;

   logic seen_disc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_disc_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_disc) begin
         seen_disc_ff <= 1'b1;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_ip)
                                  && $stable(rsp_port) && $stable(rsp_disc))
      else $error("result changed while stalled");

   a_idle_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_ok_discovered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_disc)
      else $error("success without discovered endpoint");

   a_disc_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_disc_ff |-> rsp_disc)
      else $error("discovered flag dropped");

endmodule

bind stun_mapped_address_parser_top smap_checker u_smap_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_ip     (rsp_chan.mapped_ip),
   .rsp_port   (rsp_chan.mapped_port),
   .rsp_disc   (rsp_chan.discovered)
);

### tb/stun_mapped_address_parser_top_tb.sv
// Self-checking bench for the STUN mapped address parser: byte-stream stimulus, endpoint predictor.
// Depends on smap_pkg, smap_if (smap_req_if, smap_rsp_if) and stun_mapped_address_parser_top.
module stun_mapped_address_parser_top_tb;
   import smap_pkg::*;

   localparam int MAX_BYTES   = 2048;
   localparam int RANDOM_BYTES = 1250;

   typedef struct {
      status_type  status;
      logic [31:0] ip;
      logic [15:0] port;
      logic        disc;
   } parse_result_type;

   // Tracks the parse of the current response and the latched endpoint.
   class endpoint_tracker_type;
      int          pos, msg_len, budget, attr_off, kind, alen;
      bit          hdr_bad, stopped, found;
      logic [47:0] capture;
      logic [31:0] saved_ip;
      logic [15:0] saved_port;
      bit          known;
      int          errors;
      parse_result_type expected_endpoints[$];

      function new();
         clear_parse();
         saved_ip   = '0;
         saved_port = '0;
         known      = 0;
         errors     = 0;
      endfunction

      function void clear_parse();
         pos = 0; msg_len = 0; budget = 0; attr_off = 0; kind = 0; alen = 0;
         hdr_bad = 0; stopped = 0; found = 0;
         capture = '0;
      endfunction

      function int attr_span();
         return 4 + ((alen + 3) & ~3);
      endfunction

      function void walk(int p, logic [7:0] b);
         int r;
         r = p - attr_off;
         if (r >= 4 && r == attr_span()) begin
            attr_off = p;
            r = 0;
         end
         case (r)
            0: begin
               if (budget < 4) stopped = 1;
               else kind = int'(b) * 256;
            end
            1: kind = kind | int'(b);
            2: alen = int'(b) * 256;
            3: begin
               alen = alen | int'(b);
               if (attr_span() > budget) stopped = 1;
               else budget = budget - attr_span();
            end
            default: begin
               if (kind == int'(KIND_XOR_MAPPED) && alen >= 8 && r <= 11) begin
                  if (r == 5) begin
                     // wrong family: drop the candidate, keep walking
                     if (b != FAMILY_IPV4) kind = 0;
                  end else if (r >= 6) begin
                     capture = {capture[39:0], b};
                     if (r == 11) found = 1;
                  end
               end
            end
         endcase
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         int p;
         parse_result_type e;
         if (pos < MAX_BYTES) begin
            p   = pos;
            pos = pos + 1;
            if (p < 2) begin
               if (b != TYPE_BYTE) hdr_bad = 1;
            end else if (p == 2) begin
               msg_len = int'(b) * 256;
            end else if (p == 3) begin
               msg_len  = msg_len | int'(b);
               budget   = msg_len;
               attr_off = ATTR_START;
            end else if (p >= ATTR_START && !stopped && !found) begin
               walk(p, b);
            end
         end
         if (last) begin
            if (pos < MIN_RESPONSE) begin
               e.status = STATUS_SHORT;
            end else if (hdr_bad || !found) begin
               e.status = STATUS_NO_ADDR;
            end else begin
               e.status   = STATUS_OK;
               saved_port = capture[47:32] ^ PORT_MASK;
               saved_ip   = capture[31:0] ^ IP_MASK;
               known      = 1;
            end
            e.ip   = saved_ip;
            e.port = saved_port;
            e.disc = known;
            expected_endpoints.push_back(e);
            clear_parse();
         end
      endfunction

      function void match_result(status_type st, logic [31:0] ip, logic [15:0] port,
                                 logic disc);
         parse_result_type e;
         if (expected_endpoints.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: status %0d ip %h port %h disc %0b",
                     $time, st, ip, port, disc);
            return;
         end
         e = expected_endpoints.pop_front();
         if (e.status !== st || e.ip !== ip || e.port !== port || e.disc !== disc) begin
            errors++;
            $display("%0t: expected %0d/%h/%h/%0b, got %0d/%h/%h/%0b (status/ip/port/disc)",
                     $time, e.status, e.ip, e.port, e.disc, st, ip, port, disc);
         end
      endfunction

      function void check_drained();
         if (expected_endpoints.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived, expected status %0d next",
                     $time, expected_endpoints.size(), expected_endpoints[0].status);
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   smap_req_if req_chan ();
   smap_rsp_if rsp_chan ();

   stun_mapped_address_parser_top #(.MAX_MESSAGE_BYTES(MAX_BYTES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   endpoint_tracker_type tracker = new();

   logic [7:0] frame[$];
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         sent_bytes = 0;
   int         frames_sent = 0;
   bit         hold_results = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      req_chan.is_last = 1'b0;
      rsp_chan.ready   = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            tracker.take_byte(req_chan.rx_byte, req_chan.is_last);
         if (rsp_chan.valid && rsp_chan.ready)
            tracker.match_result(rsp_chan.status, rsp_chan.mapped_ip, rsp_chan.mapped_port,
                                 rsp_chan.discovered);
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_results) begin
            hold_results = 0;
            rsp_chan.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      req_chan.is_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      sent_bytes++;
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
      frames_sent++;
   endtask

   task automatic pick_idling();
      case ((frames_sent / 5) % 4)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 88; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 88; end
         default: begin send_idle_pct = 11; rsp_stall_pct = 11; end
      endcase
   endtask

   task automatic build_noise(input int lo, input int hi);
      int n;
      n = $urandom_range(lo, hi);
      frame.delete();
      repeat (n) frame.push_back(8'($urandom));
      if (n >= 2 && $urandom_range(1)) begin
         frame[0] = TYPE_BYTE;
         frame[1] = TYPE_BYTE;
      end
   endtask

   task automatic build_wellformed();
      int          n_attr, xor_at, alen, sel, total, k;
      logic [15:0] akind, mlen, bogus_len;
      bit          bogus;
      frame.delete();
      repeat (2) frame.push_back(($urandom_range(99) < 8) ? 8'($urandom) : TYPE_BYTE);
      frame.push_back(8'h00);
      frame.push_back(8'h00);
      repeat (16) frame.push_back(8'($urandom));
      n_attr = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 4);
      xor_at = ($urandom_range(99) < 75) ? $urandom_range(0, 3) : -1;
      for (int a = 0; a < n_attr; a++) begin
         bogus = 0;
         if (a == xor_at) begin
            akind = KIND_XOR_MAPPED;
            sel   = $urandom_range(99);
            alen  = (sel < 45) ? 8 : (sel < 80) ? 12 : $urandom_range(0, 20);
         end else begin
            akind = ($urandom_range(99) < 20) ? KIND_XOR_MAPPED : 16'($urandom);
            alen  = $urandom_range(0, 12);
            bogus = ($urandom_range(99) < 5);
         end
         frame.push_back(akind[15:8]);
         frame.push_back(akind[7:0]);
         if (bogus) begin
            // random declared length with nothing behind it
            bogus_len = 16'($urandom);
            frame.push_back(bogus_len[15:8]);
            frame.push_back(bogus_len[7:0]);
            break;
         end
         frame.push_back(8'(alen >> 8));
         frame.push_back(8'(alen));
         for (int v = 0; v < alen; v++)
            frame.push_back((v == 1 && akind == KIND_XOR_MAPPED && $urandom_range(99) < 85)
                            ? FAMILY_IPV4 : 8'($urandom));
         while ((frame.size() - ATTR_START) % 4 != 0) frame.push_back(8'($urandom));
      end
      total = frame.size() - ATTR_START;
      sel   = $urandom_range(99);
      if (sel < 70)      mlen = 16'(total);
      else if (sel < 80) mlen = 16'(total - $urandom_range(1, 8));
      else if (sel < 90) mlen = 16'(total + $urandom_range(1, 16));
      else               mlen = 16'($urandom);
      frame[2] = mlen[15:8];
      frame[3] = mlen[7:0];
      sel = $urandom_range(99);
      if (sel < 20) begin
         // cut the tail so that declared bytes never arrive
         k = $urandom_range(1, 12);
         while (k > 0 && frame.size() > 1) begin
            void'(frame.pop_back());
            k--;
         end
      end else if (sel < 40) begin
         repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
      end
   endtask

   initial begin
      int sel, guard;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: lone extreme bytes, a short response with a good header and one with a bad header
      frame = '{8'hFF};
      send_frame();
      frame = '{8'h00};
      send_frame();
      frame = '{8'h01, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h80};
      send_frame();
      frame = '{8'h55, 8'hAA, 8'h7F, 8'h01};
      send_frame();

      // hold results back while short responses keep coming, so the input stalls
      hold_results = 1;
      repeat (14) begin
         build_noise(1, 6);
         send_frame();
      end

      while (sent_bytes < RANDOM_BYTES) begin
         pick_idling();
         sel = $urandom_range(99);
         if (sel < 10) begin
            build_noise(1, 31);
         end else if (sel < 15) begin
            build_noise(32, 64);
         end else begin
            build_wellformed();
         end
         send_frame();
      end

      req_chan.valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      guard = 0;
      while (tracker.expected_endpoints.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      tracker.check_drained();
      if (tracker.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
